FILE: hw/rtl/led_strip_pulse_encoder_defines.svh
// ----------------------------------------------------------------------------
// LED strip pulse encoder assertion macros
// Shared concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_PULSE_ENCODER_DEFINES_SVH
`define LED_STRIP_PULSE_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define LSPE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset
`define LSPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LSPE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LSPE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/lspe_pkg.sv
// ----------------------------------------------------------------------------
// LED strip pulse encoder package
// Field widths, register indexes, reset values, opcodes, frame constants and the phase type.
// ----------------------------------------------------------------------------
package lspe_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 16;
    localparam int unsigned ColourWidth   = 8;
    localparam int unsigned TickWidth     = 6;
    localparam int unsigned GapWidth      = 16;
    localparam int unsigned LedWidth      = 8;

    // Configuration register indexes
    localparam logic [CfgIndexWidth-1:0] REG_LED_COUNT   = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_ZERO_HIGH   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_ONE_HIGH    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_BIT_PERIOD  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_LATCH       = 3'd4;

    // Register reset values
    localparam logic [LedWidth-1:0]  RST_LED_COUNT  = 8'd20;
    localparam logic [TickWidth-1:0] RST_ZERO_HIGH  = 6'd5;
    localparam logic [TickWidth-1:0] RST_ONE_HIGH   = 6'd13;
    localparam logic [TickWidth-1:0] RST_BIT_PERIOD = 6'd20;
    localparam logic [GapWidth-1:0]  RST_LATCH      = 16'd800;

    // Input opcode
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Frame sequencing
    localparam logic [2:0] LAST_BIT  = 3'd7;
    localparam logic [1:0] LAST_BYTE = 2'd2;
    localparam logic [1:0] BYTE_G    = 2'd0;
    localparam logic [1:0] BYTE_R    = 2'd1;
    localparam logic [1:0] BYTE_B    = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_GAP  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

endpackage

FILE: hw/rtl/led_strip_pulse_encoder.sv
// ----------------------------------------------------------------------------
// LED strip pulse encoder
// One transaction in is one tick of the single-wire LED waveform; each tick
// yields one transaction out with the line level, busy and frame end.
// ----------------------------------------------------------------------------
// Each result is registered in the output register when its transaction is accepted.
// Throughput: 1 transaction per cycle while m_tready is high; the sequencer state
//   and output register update in the same cycle, so ticks stream back to back.
// Reset: asynchronous, active low; sequencer idle, counters and colour zero,
//   registers at their default values, output register empty.
`include "led_strip_pulse_encoder_defines.svh"

module led_strip_pulse_encoder
    import lspe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration write port
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    // Input stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [23:0]              s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                     s_tuser,   // opcode
    // Output stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // line_level[0], busy_res[1], zero[7:2]
    output logic                     m_tlast    // frame_done
);

    // Configuration registers
    logic [LedWidth-1:0]  led_count_reg;
    logic [TickWidth-1:0] zero_high_reg;
    logic [TickWidth-1:0] one_high_reg;
    logic [TickWidth-1:0] bit_period_reg;
    logic [GapWidth-1:0]  latch_reg;

    // Sequencer state
    phase_t               phase_reg,       phase_next;
    logic [23:0]          colour_reg,      colour_next;
    logic [GapWidth-1:0]  gap_reg,         gap_next;
    logic [TickWidth-1:0] tick_reg,        tick_next;
    logic [2:0]           bit_reg,         bit_next;
    logic [1:0]           byte_reg,        byte_next;
    logic [LedWidth-1:0]  led_reg,         led_next;

    // Output register
    logic out_valid_reg;
    logic line_reg,  line_next;
    logic busy_reg,  busy_next;
    logic done_reg,  done_next;

    logic accept;
    logic [ColourWidth-1:0] in_red;
    logic [ColourWidth-1:0] in_green;
    logic [ColourWidth-1:0] in_blue;

    assign in_red   = s_tdata[7:0];
    assign in_green = s_tdata[15:8];
    assign in_blue  = s_tdata[23:16];

    // Take a new tick whenever the output register is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg  <= RST_LED_COUNT;
            zero_high_reg  <= RST_ZERO_HIGH;
            one_high_reg   <= RST_ONE_HIGH;
            bit_period_reg <= RST_BIT_PERIOD;
            latch_reg      <= RST_LATCH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LED_COUNT:  led_count_reg  <= cfg_data[LedWidth-1:0];
                REG_ZERO_HIGH:  zero_high_reg  <= cfg_data[TickWidth-1:0];
                REG_ONE_HIGH:   one_high_reg   <= cfg_data[TickWidth-1:0];
                REG_BIT_PERIOD: bit_period_reg <= cfg_data[TickWidth-1:0];
                REG_LATCH:      latch_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Compute one tick of the waveform and the next sequencer state
    always_comb
    begin
        logic [7:0]           cur_byte;
        logic                 cur_bit;
        logic [TickWidth-1:0] high_ticks;
        logic [TickWidth-1:0] tick_inc;
        logic [LedWidth:0]    led_inc;

        phase_next  = phase_reg;
        colour_next = colour_reg;
        gap_next    = gap_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        led_next    = led_reg;
        line_next   = 1'b0;
        busy_next   = 1'b0;
        done_next   = 1'b0;

        if (phase_next != PH_GAP && phase_next != PH_DATA)
        begin
            phase_next = PH_IDLE;
        end

        // Start a frame from idle: latch colour, clear counters
        if (phase_next == PH_IDLE && s_tuser == OP_START)
        begin
            colour_next = {in_green, in_red, in_blue};
            gap_next    = '0;
            tick_next   = '0;
            bit_next    = '0;
            byte_next   = '0;
            led_next    = '0;
            phase_next  = (latch_reg != '0) ? PH_GAP : PH_DATA;
        end

        // Pick the bit in flight, green then red then blue, MSB first
        case (byte_next)
            BYTE_G:  cur_byte = colour_next[23:16];
            BYTE_R:  cur_byte = colour_next[15:8];
            BYTE_B:  cur_byte = colour_next[7:0];
            default: cur_byte = 8'h00;
        endcase
        cur_bit    = cur_byte[LAST_BIT - bit_next];
        high_ticks = cur_bit ? one_high_reg : zero_high_reg;
        tick_inc   = tick_next + 1'b1;
        led_inc    = {1'b0, led_next} + 1'b1;

        case (phase_next)
            PH_GAP:
            begin
                busy_next = 1'b1;
                gap_next  = gap_next + 1'b1;
                if (gap_next >= latch_reg)
                begin
                    gap_next   = '0;
                    tick_next  = '0;
                    bit_next   = '0;
                    byte_next  = '0;
                    led_next   = '0;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                busy_next = 1'b1;
                line_next = (tick_next < high_ticks);
                tick_next = tick_inc;
                // Advance bit, byte and LED at the end of a bit period
                if (tick_inc >= bit_period_reg || tick_inc == '0)
                begin
                    tick_next = '0;
                    if (bit_next != LAST_BIT)
                    begin
                        bit_next = bit_next + 1'b1;
                    end
                    else
                    begin
                        bit_next = '0;
                        if (byte_next < LAST_BYTE)
                        begin
                            byte_next = byte_next + 1'b1;
                        end
                        else
                        begin
                            byte_next = '0;
                            if (led_inc >= {1'b0, led_count_reg})
                            begin
                                done_next  = 1'b1;
                                gap_next   = '0;
                                led_next   = '0;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                led_next = led_inc[LedWidth-1:0];
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Advance the sequencer on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            colour_reg <= '0;
            gap_reg    <= '0;
            tick_reg   <= '0;
            bit_reg    <= '0;
            byte_reg   <= '0;
            led_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            colour_reg <= colour_next;
            gap_reg    <= gap_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            led_reg    <= led_next;
        end
    end

    // Hold the result until the downstream takes the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_reg <= line_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, busy_reg, line_reg};
    assign m_tlast  = done_reg;

    // Checks on the sequencer and output register
    `LSPE_ASSERT_IMPLY(a_line_needs_busy, clk, rst_n, m_tvalid && m_tdata[0], m_tdata[1])
    `LSPE_ASSERT_IMPLY(a_done_needs_busy, clk, rst_n, m_tvalid && m_tlast, m_tdata[1])
    `LSPE_ASSERT_IMPLY(a_idle_counters_clear, clk, rst_n, phase_reg == PH_IDLE, tick_reg == '0 && bit_reg == '0 && byte_reg == '0 && led_reg == '0)
    `LSPE_ASSERT_NEXT(a_stall_holds_done, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(done_reg))

endmodule
